FILE: rtl/block_mean_abs_envelope_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mean absolute value envelope block.
// The macros expect signals named clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MEAN_ABS_ENVELOPE_MACROS_SVH
`define BLOCK_MEAN_ABS_ENVELOPE_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define BMAE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define BMAE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bmae_pkg.sv
// ----------------------------------------------------------------------------
// bmae_pkg
// Shared types and constants of the mean absolute value envelope block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmae_pkg;

	// Default values of the top-level parameters.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ACC_BITS_DEF    = 48;

	// Fixed field widths.
	localparam int TOTAL_BITS     = 32;
	localparam int COUNT_BITS     = 16;
	localparam int AMP_BITS       = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	// Depth of the job queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Block count after reset.
	localparam logic [COUNT_BITS-1:0] DEFAULT_BLOCKS = 16'd1000;

	// Configuration register indexes.
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	localparam cfg_index_t REG_TOTAL  = 2'd0;
	localparam cfg_index_t REG_BLOCKS = 2'd1;

	// Kinds of jobs carried through the queue.
	typedef enum logic [1:0] {
		JOB_MEAN = 2'd0,
		JOB_ZERO = 2'd1,
		JOB_SIZE = 2'd2
	} job_kind_t;

	// Job description that travels with dividend and divisor.
	typedef struct packed {
		job_kind_t             kind;
		logic [COUNT_BITS-1:0] index;
		logic                  last;
	} job_meta_t;

	// Block size result returned from the back to the front.
	typedef struct packed {
		logic                  valid;
		logic [TOTAL_BITS-1:0] quotient;
		logic [COUNT_BITS-1:0] remainder;
	} size_resp_t;

endpackage

`default_nettype wire

FILE: rtl/bmae_fifo.sv
// ----------------------------------------------------------------------------
// bmae_fifo
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bmae_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bmae_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bmae_div.sv
// ----------------------------------------------------------------------------
// bmae_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmae_div #(
	parameter int DIV_BITS = 48
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [DIV_BITS-1:0]             dividend,
	input  wire logic [bmae_pkg::TOTAL_BITS-1:0] divisor,
	output logic                                 done,
	output logic      [DIV_BITS-1:0]             quotient,
	output logic      [bmae_pkg::TOTAL_BITS-1:0] remainder
);

	localparam int DVS_BITS = bmae_pkg::TOTAL_BITS;
	localparam int CNT_BITS = $clog2(DIV_BITS + 1);

	logic [DIV_BITS-1:0] quo_q;
	logic [DVS_BITS-1:0] rem_q;
	logic [DVS_BITS-1:0] divisor_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DVS_BITS:0]   trial;
	logic [DVS_BITS:0]   diff;
	logic                fits;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign trial = {rem_q, quo_q[DIV_BITS-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = (trial >= {1'b0, divisor_q});

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
			rem_q <= fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_BITS'(DIV_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bmae_front.sv
// ----------------------------------------------------------------------------
// bmae_front
// Holds the configuration, accumulates absolute sample values per block and
// queues one division job for every finished block or size computation.
// ----------------------------------------------------------------------------
`default_nettype none

module bmae_front #(
	parameter int SAMPLE_BITS = bmae_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_BITS    = bmae_pkg::ACC_BITS_DEF,
	parameter int DIV_BITS    = 48
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// Item channel.
	input  wire logic                                    push,
	output logic                                         full,
	input  wire logic                                    action,
	input  wire logic signed [SAMPLE_BITS-1:0]           sample,
	// Configuration channel.
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire bmae_pkg::cfg_index_t                    cfg_index,
	input  wire logic        [bmae_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// Job queue.
	output logic                                         q_push,
	output bmae_pkg::job_meta_t                          q_meta,
	output logic             [DIV_BITS-1:0]              q_dividend,
	output logic             [bmae_pkg::TOTAL_BITS-1:0]  q_divisor,
	input  wire logic                                    q_full,
	// Block size result.
	input  wire bmae_pkg::size_resp_t                    size_resp
);

	localparam int TB       = bmae_pkg::TOTAL_BITS;
	localparam int CB       = bmae_pkg::COUNT_BITS;
	localparam int SUM_BITS = ((ACC_BITS > SAMPLE_BITS) ? ACC_BITS : SAMPLE_BITS) + 1;

	logic [TB-1:0]          total_q;
	logic [CB-1:0]          blocks_q;
	logic [TB-1:0]          base_q;
	logic [CB-1:0]          extra_q;
	logic                   sizes_valid_q;
	logic                   need_q;
	logic                   inflight_q;
	logic [CB-1:0]          cur_q;
	logic [TB-1:0]          fill_q;
	logic [TB-1:0]          cur_size_q;
	logic [ACC_BITS-1:0]    sum_q;

	logic                   wr_total;
	logic                   wr_blocks;
	logic                   cfg_hit;
	logic                   accept;
	logic                   enabled;
	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SUM_BITS-1:0]    sum_wide;
	logic [ACC_BITS-1:0]    sum_sat;
	logic [CB:0]            cur_plus;
	logic                   is_last;
	logic [TB-1:0]          size_next;
	logic [TB-1:0]          size_first;
	logic [TB-1:0]          fill_plus;
	logic                   take_sample;
	logic                   take_flush;
	logic                   close_block;
	logic                   issue;
	logic [TB-1:0]          resp_base;
	logic [CB-1:0]          resp_extra;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	assign wr_total  = cfg_valid && (cfg_index == bmae_pkg::REG_TOTAL);
	assign wr_blocks = cfg_valid && (cfg_index == bmae_pkg::REG_BLOCKS);
	assign cfg_hit   = wr_total || wr_blocks;

	// Items wait while block sizes are being derived or the queue is full.
	assign full    = !sizes_valid_q || q_full;
	assign accept  = push && !full;
	assign enabled = (total_q != '0) && (blocks_q != '0);

	// Magnitude and saturating accumulation.
	assign raw      = sample;
	assign mag      = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
	assign sum_wide = SUM_BITS'(sum_q) + SUM_BITS'(mag);
	assign sum_sat  = (sum_wide[SUM_BITS-1:ACC_BITS] != '0) ? '1 : sum_wide[ACC_BITS-1:0];

	// Block bookkeeping.
	assign cur_plus   = {1'b0, cur_q} + (CB + 1)'(1);
	assign is_last    = (cur_plus >= {1'b0, blocks_q});
	assign size_next  = base_q + TB'(cur_plus < {1'b0, extra_q});
	assign size_first = base_q + TB'(extra_q != '0);
	assign fill_plus  = fill_q + TB'(1);

	assign take_sample = accept && enabled && !action && (cur_size_q != '0);
	assign take_flush  = accept && enabled && action && (cur_size_q == '0);
	assign close_block = take_flush || (take_sample && (fill_plus == cur_size_q));
	assign issue       = need_q && !inflight_q && !q_full;

	// A zero block count leaves both sizes at zero.
	assign resp_base  = (blocks_q == '0) ? '0 : size_resp.quotient;
	assign resp_extra = (blocks_q == '0) ? '0 : size_resp.remainder;

	// Job request toward the back.
	assign q_push = close_block || issue;
	always_comb begin
		q_meta.index = cur_q;
		q_meta.last  = is_last;
		if (issue) begin
			q_meta.kind = bmae_pkg::JOB_SIZE;
			q_dividend  = DIV_BITS'(total_q);
			q_divisor   = TB'(blocks_q);
		end else if (action) begin
			q_meta.kind = bmae_pkg::JOB_ZERO;
			q_dividend  = '0;
			q_divisor   = cur_size_q;
		end else begin
			q_meta.kind = bmae_pkg::JOB_MEAN;
			q_dividend  = DIV_BITS'(sum_q == sum_q ? sum_sat : sum_sat);
			q_divisor   = cur_size_q;
		end
	end

	// Configuration, size derivation and per-block counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= '0;
			blocks_q      <= bmae_pkg::DEFAULT_BLOCKS;
			base_q        <= '0;
			extra_q       <= '0;
			sizes_valid_q <= 1'b1;
			need_q        <= 1'b0;
			inflight_q    <= 1'b0;
			cur_q         <= '0;
			fill_q        <= '0;
			cur_size_q    <= '0;
			sum_q         <= '0;
		end else begin
			// Size request handed to the back.
			if (issue) begin
				need_q     <= 1'b0;
				inflight_q <= 1'b1;
			end
			// Size result; dropped when a newer write is pending.
			if (size_resp.valid) begin
				inflight_q <= 1'b0;
				if (!need_q) begin
					sizes_valid_q <= 1'b1;
					base_q        <= resp_base;
					extra_q       <= resp_extra;
					cur_size_q    <= resp_base + TB'(resp_extra != '0);
				end
			end
			// Accumulate, or close the block and move to the next one.
			if (close_block) begin
				fill_q <= '0;
				sum_q  <= '0;
				if (is_last) begin
					cur_q      <= '0;
					cur_size_q <= size_first;
				end else begin
					cur_q      <= cur_plus[CB-1:0];
					cur_size_q <= size_next;
				end
			end else if (take_sample) begin
				fill_q <= fill_plus;
				sum_q  <= sum_sat;
			end
			// A register write restarts the stream and rederives the sizes.
			if (cfg_hit) begin
				if (wr_total) begin
					total_q <= cfg_data[TB-1:0];
				end
				if (wr_blocks) begin
					blocks_q <= cfg_data[CB-1:0];
				end
				need_q        <= 1'b1;
				sizes_valid_q <= 1'b0;
				cur_q         <= '0;
				fill_q        <= '0;
				sum_q         <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bmae_back.sv
// ----------------------------------------------------------------------------
// bmae_back
// Takes jobs from the queue, runs them through the divider and delivers
// block results into the output register or sizes back to the front.
// ----------------------------------------------------------------------------
`default_nettype none

module bmae_back #(
	parameter int DIV_BITS = 48
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Job queue.
	input  wire logic                                 q_empty,
	output logic                                      q_pop,
	input  wire bmae_pkg::job_meta_t                  q_meta,
	input  wire logic [DIV_BITS-1:0]                  q_dividend,
	input  wire logic [bmae_pkg::TOTAL_BITS-1:0]      q_divisor,
	// Block size result.
	output bmae_pkg::size_resp_t                      size_resp,
	// Result channel.
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic      [bmae_pkg::AMP_BITS-1:0]        amplitude,
	output logic      [bmae_pkg::COUNT_BITS-1:0]      block_index,
	output logic                                      last_block
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} back_state_t;

	back_state_t                          state_q;
	bmae_pkg::job_meta_t                  meta_q;
	logic                                 div_start;
	logic                                 div_done;
	logic [DIV_BITS-1:0]                  quotient;
	logic [bmae_pkg::TOTAL_BITS-1:0]      remainder;
	logic                                 out_valid_q;
	logic [bmae_pkg::AMP_BITS-1:0]        amplitude_q;
	logic [bmae_pkg::COUNT_BITS-1:0]      block_index_q;
	logic                                 last_block_q;
	logic                                 out_free;
	logic                                 is_size;
	logic                                 load_out;

	bmae_div #(
		.DIV_BITS(DIV_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_dividend),
		.divisor  (q_divisor),
		.done     (div_done),
		.quotient (quotient),
		.remainder(remainder)
	);

	// Job intake.
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign div_start = q_pop && (q_meta.kind != bmae_pkg::JOB_ZERO);

	// Completion toward the front or the output register.
	assign is_size   = (meta_q.kind == bmae_pkg::JOB_SIZE);
	assign out_free  = !out_valid_q || pop;
	assign load_out  = (state_q == ST_HOLD) && !is_size && out_free;

	assign size_resp.valid     = (state_q == ST_HOLD) && is_size;
	assign size_resp.quotient  = quotient[bmae_pkg::TOTAL_BITS-1:0];
	assign size_resp.remainder = remainder[bmae_pkg::COUNT_BITS-1:0];

	assign empty       = !out_valid_q;
	assign amplitude   = amplitude_q;
	assign block_index = block_index_q;
	assign last_block  = last_block_q;

	// Job sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= (q_meta.kind == bmae_pkg::JOB_ZERO) ? ST_HOLD : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (is_size || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Job description of the job at work.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			meta_q <= q_meta;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			amplitude_q   <= (meta_q.kind == bmae_pkg::JOB_ZERO) ?
				'0 : quotient[bmae_pkg::AMP_BITS-1:0];
			block_index_q <= meta_q.index;
			last_block_q  <= meta_q.last;
		end
	end

	// Output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/block_mean_abs_envelope.sv
// ----------------------------------------------------------------------------
// block_mean_abs_envelope
// Mean absolute value envelope: splits a sample stream into blocks and
// reports the truncated mean magnitude of each block.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter through push/full with an action and a sample; flush items
//   close pending empty blocks. Results leave through empty/pop as
//   amplitude, block_index and last_block; at most one result per item.
//   The configuration channel (cfg_valid/cfg_ready, always ready) writes
//   total_samples at index 0 and block_count at index 1. A write restarts
//   the stream and holds full high while the block size is derived in the
//   DIV_BITS-wide divider, DIV_BITS being the wider of ACC_BITS and 32.
//   Throughput: one item per cycle in the front while full is low. Each
//   finished mean block runs through the one-bit-per-cycle divider in
//   the back, one job at a time; a four-entry job queue absorbs bursts
//   of short blocks.
//   Reset clears all counters, sets total_samples to 0 and block_count to
//   1000, and needs no clearing pass. When the receiver stalls, the result
//   holds in the output register, then the queue fills and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module block_mean_abs_envelope #(
	parameter int SAMPLE_BITS = bmae_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_BITS    = bmae_pkg::ACC_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	// Item channel.
	input  wire logic                                      push,
	output logic                                           full,
	input  wire logic                                      action,
	input  wire logic signed [SAMPLE_BITS-1:0]             sample,
	// Result channel.
	output logic                                           empty,
	input  wire logic                                      pop,
	output logic             [bmae_pkg::AMP_BITS-1:0]      amplitude,
	output logic             [bmae_pkg::COUNT_BITS-1:0]    block_index,
	output logic                                           last_block,
	// Configuration channel.
	input  wire logic                                      cfg_valid,
	output logic                                           cfg_ready,
	input  wire bmae_pkg::cfg_index_t                      cfg_index,
	input  wire logic        [bmae_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int TB        = bmae_pkg::TOTAL_BITS;
	localparam int DIV_BITS  = (ACC_BITS > TB) ? ACC_BITS : TB;
	localparam int META_BITS = $bits(bmae_pkg::job_meta_t);
	localparam int JOB_BITS  = META_BITS + DIV_BITS + TB;

	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;
	bmae_pkg::job_meta_t  push_meta;
	logic [DIV_BITS-1:0]  push_dividend;
	logic [TB-1:0]        push_divisor;
	logic [JOB_BITS-1:0]  q_wdata;
	logic [JOB_BITS-1:0]  q_rdata;
	bmae_pkg::job_meta_t  pop_meta;
	logic [DIV_BITS-1:0]  pop_dividend;
	logic [TB-1:0]        pop_divisor;
	bmae_pkg::size_resp_t size_resp;

	bmae_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.ACC_BITS   (ACC_BITS),
		.DIV_BITS   (DIV_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.sample    (sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_meta    (push_meta),
		.q_dividend(push_dividend),
		.q_divisor (push_divisor),
		.q_full    (q_full),
		.size_resp (size_resp)
	);

	// Job words: description, dividend, divisor.
	assign q_wdata      = {push_meta, push_dividend, push_divisor};
	assign pop_meta     = bmae_pkg::job_meta_t'(q_rdata[JOB_BITS-1 -: META_BITS]);
	assign pop_dividend = q_rdata[TB +: DIV_BITS];
	assign pop_divisor  = q_rdata[TB-1:0];

	bmae_fifo #(
		.WIDTH(JOB_BITS),
		.DEPTH(bmae_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	bmae_back #(
		.DIV_BITS(DIV_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_meta     (pop_meta),
		.q_dividend (pop_dividend),
		.q_divisor  (pop_divisor),
		.size_resp  (size_resp),
		.empty      (empty),
		.pop        (pop),
		.amplitude  (amplitude),
		.block_index(block_index),
		.last_block (last_block)
	);

endmodule

`default_nettype wire

FILE: rtl/bmae_checker.sv
// ----------------------------------------------------------------------------
// bmae_checker
// Port-level checks of the envelope block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_mean_abs_envelope_macros.svh"

module bmae_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               full,
	input wire logic                               empty,
	input wire logic                               pop,
	input wire logic [bmae_pkg::AMP_BITS-1:0]      amplitude,
	input wire logic [bmae_pkg::COUNT_BITS-1:0]    block_index,
	input wire logic                               last_block,
	input wire logic                               cfg_valid,
	input wire logic                               cfg_ready,
	input wire bmae_pkg::cfg_index_t               cfg_index
);

	logic [bmae_pkg::COUNT_BITS-1:0] exp_index_q;
	logic                            cfg_write;

	assign cfg_write = cfg_valid && cfg_ready &&
		((cfg_index == bmae_pkg::REG_TOTAL) || (cfg_index == bmae_pkg::REG_BLOCKS));

	// Index the next result must carry: blocks come in order and wrap after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_index_q <= '0;
		end else if (cfg_write) begin
			exp_index_q <= '0;
		end else if (pop && !empty) begin
			exp_index_q <= last_block ? '0 : block_index + 1'b1;
		end
	end

	`BMAE_ASSERT_SAME(a_index_order, !empty, block_index == exp_index_q, "result index out of order")
	`BMAE_ASSERT_NEXT(a_cfg_stalls_items, cfg_write, full, "items accepted before sizes are derived")
	`BMAE_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(amplitude) && $stable(block_index) && $stable(last_block), "waiting result changed")

endmodule

bind block_mean_abs_envelope bmae_checker u_checker (.*);

`default_nettype wire
